FILE: rtl/dlttq_pkg.sv
// Package for the delta-list task timer queue.
// Holds operation and status codes and the command bundle sent to the cell row.
// No dependencies.
`timescale 1ns / 1ps

package dlttq_pkg;

   // Operation codes carried in the request transaction.
   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_ADD      = 2'd1;
   localparam logic [1:0] OP_DISPATCH = 2'd2;

   // Status codes carried in the response transaction.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_NOT_DUE = 2'd2;

   // Commands broadcast from the controller to every cell.
   typedef struct packed {
      logic tick;     // count the head down
      logic pop;      // remove the head, every cell takes from its right neighbor
      logic start;    // load the insertion token into the head cell
      logic ins_now;  // some cell inserts this cycle, cells past the token shift right
   } cmd_type;

endpackage

FILE: rtl/dlttq_cell.sv
// One cell of the delta-list timer queue: holds one list entry and the walking
// insertion token. Depends on dlttq_pkg.
`timescale 1ns / 1ps

module dlttq_cell import dlttq_pkg::*; #(
   parameter int DELAY_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic                  head_pos,
   input  logic                  occupied,
   input  logic [7:0]            new_task,
   input  logic [DELAY_BITS-1:0] new_period,
   input  logic [DELAY_BITS-1:0] new_rem,
   input  logic [7:0]            left_task,
   input  logic [DELAY_BITS-1:0] left_delta,
   input  logic [DELAY_BITS-1:0] left_period,
   input  logic                  left_due,
   input  logic [DELAY_BITS-1:0] left_rem,
   input  logic                  left_ins,
   input  logic                  left_tokp,
   input  logic [7:0]            right_task,
   input  logic [DELAY_BITS-1:0] right_delta,
   input  logic [DELAY_BITS-1:0] right_period,
   input  logic                  right_due,
   output logic [7:0]            cell_task,
   output logic [DELAY_BITS-1:0] cell_delta,
   output logic [DELAY_BITS-1:0] cell_period,
   output logic                  cell_due,
   output logic [DELAY_BITS-1:0] cell_rem,
   output logic                  cell_ins,
   output logic                  cell_tokp
);

   logic [7:0]            task_ff,   task_in;
   logic [DELAY_BITS-1:0] delta_ff,  delta_in;
   logic [DELAY_BITS-1:0] period_ff, period_in;
   logic                  due_ff,    due_in;
   logic                  tok_ff,    tok_in;
   logic [DELAY_BITS-1:0] rem_ff,    rem_in;
   logic                  ahead_ff,  ahead_in;

   // The token stops here when the slot is free or this entry runs no earlier
   // than the remaining delay; otherwise it moves on to the right.
   assign cell_ins  = tok_ff && (!occupied || (delta_ff >= rem_ff));
   assign cell_tokp = tok_ff && !cell_ins;

   assign cell_task   = task_ff;
   assign cell_delta  = delta_ff;
   assign cell_period = period_ff;
   assign cell_due    = due_ff;
   assign cell_rem    = rem_ff;

   // Entry update: pop, tick, insert here, or shift right behind an insertion.
   always_comb begin
      task_in   = task_ff;
      delta_in  = delta_ff;
      period_in = period_ff;
      due_in    = due_ff;
      if (cmd.pop) begin
         task_in   = right_task;
         delta_in  = right_delta;
         period_in = right_period;
         due_in    = right_due;
      end else if (cmd.tick && head_pos && occupied && !due_ff) begin
         if (delta_ff != '0) begin
            delta_in = delta_ff - 1'b1;
         end
         due_in = (delta_ff == '0) || (delta_ff == DELAY_BITS'(1));
      end else if (cell_ins) begin
         task_in   = new_task;
         delta_in  = rem_ff;
         period_in = new_period;
         due_in    = 1'b0;
      end else if (cmd.ins_now && ahead_ff) begin
         task_in   = left_task;
         delta_in  = left_ins ? (left_delta - left_rem) : left_delta;
         period_in = left_period;
         due_in    = left_due;
      end
   end

   // Token handoff: the remaining delay shrinks by each entry it walks past.
   always_comb begin
      tok_in   = (head_pos && cmd.start) || left_tokp;
      rem_in   = rem_ff;
      ahead_in = ahead_ff;
      if (head_pos && cmd.start) begin
         rem_in = new_rem;
      end else if (left_tokp) begin
         rem_in = left_rem - left_delta;
      end
      if (cmd.start) begin
         ahead_in = !head_pos;
      end else if (left_tokp) begin
         ahead_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= 1'b0;
         ahead_ff <= 1'b0;
         due_ff   <= 1'b0;
      end else begin
         tok_ff   <= tok_in;
         ahead_ff <= ahead_in;
         due_ff   <= due_in;
      end
   end

   // Entry payload.
   always_ff @(posedge clock) begin
      task_ff   <= task_in;
      delta_ff  <= delta_in;
      period_ff <= period_in;
      rem_ff    <= rem_in;
   end

endmodule

FILE: rtl/delta_list_task_timer_queue_unit.sv
// Top level of the delta-list task timer queue: controller, result register and
// the row of dlttq_cell entries. Depends on dlttq_pkg and dlttq_cell.
`timescale 1ns / 1ps
//
//  Channel | Direction | Ports                           | Contents
//  --------+-----------+---------------------------------+---------------------------------
//  req     | in        | req_tvalid, req_tready, req_tdata | one operation per transaction
//  rsp     | out       | rsp_tvalid, rsp_tready, rsp_tdata, rsp_tuser | one result per operation
//
//  One operation is worked at a time. Tick, unused opcode, full-table add, and
//  dispatch without a due head go from S_EXEC straight to S_REPLY.
//  Add and periodic dispatch pass through S_WALK until the token reaches the insertion
//  position: the token walks one cell per cycle, at most MAX_TASKS cells.
//  The next request is taken as soon as the result sits in the output register.
//  Reset is synchronous and active high; it empties the list, no clearing pass.
//  A stalled response holds the controller before loading the next result.

module delta_list_task_timer_queue_unit import dlttq_pkg::*; #(
   parameter int MAX_TASKS  = 16,
   parameter int DELAY_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] opcode, [9:2] task_id, [25:10] start_delay, [41:26] repeat_period
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] run_task_id, [9:8] status, [14:10] task_count
   output logic [15:0] rsp_tdata,
   // [0] run_valid
   output logic        rsp_tuser
);

   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam int IW = (DELAY_BITS > 16) ? DELAY_BITS : 16;
   localparam logic [IW-1:0] DMAX_W = IW'({DELAY_BITS{1'b1}});

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_EXEC  = 4'b0010,
      S_WALK  = 4'b0100,
      S_REPLY = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0]         count_ff, count_in;
   logic [1:0]            op_ff;
   logic [7:0]            id_ff;
   logic [DELAY_BITS-1:0] delay_ff, period_ff;
   logic [7:0]            new_task_ff, new_task_in;
   logic [DELAY_BITS-1:0] new_period_ff, new_period_in;
   logic [DELAY_BITS-1:0] new_rem;
   logic                  res_valid_ff, res_valid_in;
   logic [7:0]            res_id_ff, res_id_in;
   logic [1:0]            res_status_ff, res_status_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0]           rsp_tdata_ff, rsp_tdata_in;
   logic                  rsp_tuser_ff, rsp_tuser_in;

   logic                  req_fire;
   logic                  rsp_free;
   cmd_type               cmd;
   logic [IW-1:0]         delay_ext, period_ext;

   logic [7:0]            c_task   [MAX_TASKS];
   logic [DELAY_BITS-1:0] c_delta  [MAX_TASKS];
   logic [DELAY_BITS-1:0] c_period [MAX_TASKS];
   logic [DELAY_BITS-1:0] c_rem    [MAX_TASKS];
   logic [MAX_TASKS-1:0]  c_due;
   logic [MAX_TASKS-1:0]  ins_vec;
   logic [MAX_TASKS-1:0]  tokp_vec;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;

   // Saturate incoming delays to the stored delay width.
   assign delay_ext  = IW'(req_tdata[25:10]);
   assign period_ext = IW'(req_tdata[41:26]);

   // Request capture.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff     <= req_tdata[1:0];
         id_ff     <= req_tdata[9:2];
         delay_ff  <= (delay_ext > DMAX_W) ? DELAY_BITS'(DMAX_W) : DELAY_BITS'(delay_ext);
         period_ff <= (period_ext > DMAX_W) ? DELAY_BITS'(DMAX_W) : DELAY_BITS'(period_ext);
      end
   end

   // Controller: decode in S_EXEC, walk the token in S_WALK, hand off in S_REPLY.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      new_task_in   = new_task_ff;
      new_period_in = new_period_ff;
      new_rem       = delay_ff;
      res_valid_in  = res_valid_ff;
      res_id_in     = res_id_ff;
      res_status_in = res_status_ff;
      cmd           = '0;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_valid_in  = 1'b0;
            res_id_in     = '0;
            res_status_in = ST_OK;
            state_in      = S_REPLY;
            case (op_ff)
               OP_TICK: begin
                  cmd.tick = 1'b1;
               end
               OP_ADD: begin
                  if (count_ff == CW'(MAX_TASKS)) begin
                     res_status_in = ST_FULL;
                  end else begin
                     new_task_in   = id_ff;
                     new_period_in = period_ff;
                     new_rem       = delay_ff;
                     cmd.start     = 1'b1;
                     state_in      = S_WALK;
                  end
               end
               OP_DISPATCH: begin
                  if ((count_ff != '0) && c_due[0]) begin
                     res_valid_in  = 1'b1;
                     res_id_in     = c_task[0];
                     cmd.pop       = 1'b1;
                     count_in      = count_ff - 1'b1;
                     new_task_in   = c_task[0];
                     new_period_in = c_period[0];
                     new_rem       = c_period[0];
                     if (c_period[0] != '0) begin
                        cmd.start = 1'b1;
                        state_in  = S_WALK;
                     end
                  end else begin
                     res_status_in = ST_NOT_DUE;
                  end
               end
               default: begin
               end
            endcase
         end
         S_WALK: begin
            cmd.ins_now = |ins_vec;
            if (cmd.ins_now) begin
               count_in = count_ff + 1'b1;
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {1'b0, 5'(count_ff), res_status_ff, res_id_ff};
               rsp_tuser_in  = res_valid_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      new_task_ff   <= new_task_in;
      new_period_ff <= new_period_in;
      res_valid_ff  <= res_valid_in;
      res_id_ff     <= res_id_in;
      res_status_ff <= res_status_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // The cell row; apart from the controller's broadcasts, each cell talks only to its neighbors.
   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      logic [7:0]            l_task, r_task;
      logic [DELAY_BITS-1:0] l_delta, l_period, l_rem, r_delta, r_period;
      logic                  l_due, l_ins, l_tokp, r_due;

      if (i == 0) begin : g_left_edge
         assign l_task   = '0;
         assign l_delta  = '0;
         assign l_period = '0;
         assign l_due    = 1'b0;
         assign l_rem    = '0;
         assign l_ins    = 1'b0;
         assign l_tokp   = 1'b0;
      end else begin : g_left
         assign l_task   = c_task[i-1];
         assign l_delta  = c_delta[i-1];
         assign l_period = c_period[i-1];
         assign l_due    = c_due[i-1];
         assign l_rem    = c_rem[i-1];
         assign l_ins    = ins_vec[i-1];
         assign l_tokp   = tokp_vec[i-1];
      end

      if (i == MAX_TASKS - 1) begin : g_right_edge
         assign r_task   = '0;
         assign r_delta  = '0;
         assign r_period = '0;
         assign r_due    = 1'b0;
      end else begin : g_right
         assign r_task   = c_task[i+1];
         assign r_delta  = c_delta[i+1];
         assign r_period = c_period[i+1];
         assign r_due    = c_due[i+1];
      end

      dlttq_cell #(
         .DELAY_BITS (DELAY_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .head_pos     (i == 0),
         .occupied     (count_ff > CW'(i)),
         .new_task     (new_task_ff),
         .new_period   (new_period_ff),
         .new_rem      (new_rem),
         .left_task    (l_task),
         .left_delta   (l_delta),
         .left_period  (l_period),
         .left_due     (l_due),
         .left_rem     (l_rem),
         .left_ins     (l_ins),
         .left_tokp    (l_tokp),
         .right_task   (r_task),
         .right_delta  (r_delta),
         .right_period (r_period),
         .right_due    (r_due),
         .cell_task    (c_task[i]),
         .cell_delta   (c_delta[i]),
         .cell_period  (c_period[i]),
         .cell_due     (c_due[i]),
         .cell_rem     (c_rem[i]),
         .cell_ins     (ins_vec[i]),
         .cell_tokp    (tokp_vec[i])
      );
   end

`ifndef SYNTHESIS
   // At most one cell claims the insertion in a cycle.
   a_one_insert: assert property (@(posedge clock) disable iff (reset)
      $onehot0(ins_vec))
      else $error("more than one cell inserts at once");

   // Insertions happen only while the controller walks the token.
   a_insert_in_walk: assert property (@(posedge clock) disable iff (reset)
      (|ins_vec) |-> (state_ff == S_WALK))
      else $error("cell inserts outside the walk");

   // The token never runs off the end of the row.
   a_token_bounded: assert property (@(posedge clock) disable iff (reset)
      !tokp_vec[MAX_TASKS-1])
      else $error("token passed beyond the last cell");

   // The list never holds more than the row can store.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_TASKS))
      else $error("task count exceeds capacity");

   // A walk never starts on a full list.
   a_walk_has_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (count_ff < CW'(MAX_TASKS)))
      else $error("insertion walk on a full list");
`endif

endmodule

FILE: verif/timer_queue_checker.sv
// Checker for the delta-list task timer queue: watches both streams, keeps its own
// copy of the sorted task list and compares every response with the predicted one.
// Depends on dlttq_pkg for the operation and status codes.
`timescale 1ns / 1ps

module timer_queue_checker import dlttq_pkg::*; #(
   parameter int MAX_TASKS  = 16,
   parameter int DELAY_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // [1:0] opcode, [9:2] task_id, [25:10] start_delay, [41:26] repeat_period
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] run_task_id, [9:8] status, [14:10] task_count
   input  logic [15:0] rsp_tdata,
   // [0] run_valid
   input  logic        rsp_tuser,
   output int          mismatch_count,
   output int          results_pending
);

   typedef struct packed {
      logic       run_valid;
      logic [7:0] run_task_id;
      logic [1:0] status;
      logic [4:0] task_count;
   } outcome_type;

   // Shadow copy of the timer list.
   logic [7:0]            slot_task   [MAX_TASKS];
   logic [DELAY_BITS-1:0] slot_delta  [MAX_TASKS];
   logic [DELAY_BITS-1:0] slot_period [MAX_TASKS];
   logic                  slot_due    [MAX_TASKS];
   int unsigned           slot_count;

   outcome_type pending_outcomes[$];

   // Delays wider than the list can hold saturate to its largest value.
   function automatic logic [DELAY_BITS-1:0] saturate_delay(input logic [15:0] raw);
      longint unsigned top_value;
      top_value = (64'd1 << DELAY_BITS) - 64'd1;
      return (raw > top_value) ? top_value[DELAY_BITS-1:0] : raw[DELAY_BITS-1:0];
   endfunction

   // Sorted insert ahead of the first entry whose running sum reaches the delay.
   function automatic void insert_timer(input logic [7:0] id,
                                        input logic [DELAY_BITS-1:0] delay,
                                        input logic [DELAY_BITS-1:0] period);
      longint unsigned run_sum;
      int unsigned     pos;
      run_sum = 0;
      pos     = slot_count;
      for (int unsigned i = 0; i < slot_count; i++) begin
         if (run_sum + slot_delta[i] >= delay) begin
            pos = i;
            break;
         end
         run_sum += slot_delta[i];
      end
      for (int unsigned i = slot_count; i > pos; i--) begin
         slot_task[i]   = slot_task[i-1];
         slot_delta[i]  = slot_delta[i-1];
         slot_period[i] = slot_period[i-1];
         slot_due[i]    = slot_due[i-1];
      end
      slot_task[pos]   = id;
      slot_delta[pos]  = DELAY_BITS'(delay - run_sum);
      slot_period[pos] = period;
      slot_due[pos]    = 1'b0;
      if (pos + 1 <= slot_count)
         slot_delta[pos+1] = slot_delta[pos+1] - slot_delta[pos];
      slot_count++;
   endfunction

   // Applies one operation to the shadow list and returns the response it causes.
   function automatic outcome_type apply_operation(input logic [47:0] word);
      logic [1:0]            op;
      logic [7:0]            id;
      logic [DELAY_BITS-1:0] delay;
      logic [DELAY_BITS-1:0] period;
      logic [7:0]            head_id;
      logic [DELAY_BITS-1:0] head_period;
      outcome_type           result;
      op     = word[1:0];
      id     = word[9:2];
      delay  = saturate_delay(word[25:10]);
      period = saturate_delay(word[41:26]);
      result = '0;
      result.status = ST_OK;
      case (op)
         OP_TICK: begin
            // Only a head that is not yet due counts down.
            if (slot_count > 0 && !slot_due[0]) begin
               if (slot_delta[0] != 0)
                  slot_delta[0] = slot_delta[0] - 1'b1;
               if (slot_delta[0] == 0)
                  slot_due[0] = 1'b1;
            end
         end
         OP_ADD: begin
            if (slot_count >= MAX_TASKS)
               result.status = ST_FULL;
            else
               insert_timer(id, delay, period);
         end
         OP_DISPATCH: begin
            if (slot_count > 0 && slot_due[0]) begin
               head_id            = slot_task[0];
               head_period        = slot_period[0];
               result.run_valid   = 1'b1;
               result.run_task_id = head_id;
               for (int unsigned i = 0; i + 1 < slot_count; i++) begin
                  slot_task[i]   = slot_task[i+1];
                  slot_delta[i]  = slot_delta[i+1];
                  slot_period[i] = slot_period[i+1];
                  slot_due[i]    = slot_due[i+1];
               end
               slot_count--;
               slot_due[slot_count] = 1'b0;
               // Periodic tasks go back in, one period from now.
               if (head_period != 0)
                  insert_timer(head_id, head_period, head_period);
            end else begin
               result.status = ST_NOT_DUE;
            end
         end
         default: begin
            // The unused opcode leaves the list alone.
         end
      endcase
      result.task_count = 5'(slot_count);
      return result;
   endfunction

   // Responses are checked before the request of the same edge is predicted.
   always @(posedge clock) begin
      outcome_type seen;
      outcome_type want;
      if (reset) begin
         slot_count = 0;
         for (int i = 0; i < MAX_TASKS; i++)
            slot_due[i] = 1'b0;
         pending_outcomes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.run_valid   = rsp_tuser;
            seen.run_task_id = rsp_tdata[7:0];
            seen.status      = rsp_tdata[9:8];
            seen.task_count  = rsp_tdata[14:10];
            if (pending_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected response: valid=%0b id=%0d status=%0d count=%0d",
                           seen.run_valid, seen.run_task_id, seen.status, seen.task_count);
            end else begin
               want = pending_outcomes.pop_front();
               if (seen.run_valid !== want.run_valid ||
                   seen.run_task_id !== want.run_task_id ||
                   seen.status !== want.status ||
                   seen.task_count !== want.task_count) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"Response differs: expected valid=%0b id=%0d status=%0d ",
                               "count=%0d, got valid=%0b id=%0d status=%0d count=%0d"},
                              want.run_valid, want.run_task_id, want.status,
                              want.task_count, seen.run_valid, seen.run_task_id,
                              seen.status, seen.task_count);
               end
            end
         end
         if (req_tvalid && req_tready)
            pending_outcomes.push_back(apply_operation(req_tdata));
      end
      results_pending = pending_outcomes.size();
   end

endmodule

FILE: verif/delta_list_task_timer_queue_unit_tb.sv
// Testbench top for the delta-list task timer queue: clock, reset, request and
// response traffic, watchdog and verdict. Depends on dlttq_pkg, the block and
// timer_queue_checker.
`timescale 1ns / 1ps

module delta_list_task_timer_queue_unit_tb import dlttq_pkg::*;;

   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam int         IDLE_LIMIT = 1000;
   localparam int         HOLD_OFF   = 150;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   int          mismatch_count;
   int          results_pending;
   int          idle_cycles = 0;
   bit          sender_steady   = 1'b0;
   bit          receiver_steady = 1'b0;

   delta_list_task_timer_queue_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   timer_queue_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Ends the run when no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Offers one request after a random gap and returns at the accepting edge.
   task automatic send_request(input logic [1:0] op, input logic [7:0] id,
                               input logic [15:0] delay, input logic [15:0] period);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {6'd0, period, delay, id, op};
      req_tvalid <= 1'b1;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   // Mostly short delays so that tasks come due; a few span the whole range.
   function automatic logic [15:0] pick_delay();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 75)
         return 16'($urandom_range(0, 12));
      else if (roll < 98)
         return 16'($urandom_range(0, 300));
      else
         return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_period();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return '0;
      else if (roll < 98)
         return 16'($urandom_range(1, 20));
      else
         return 16'($urandom);
   endfunction

   // Response side: random stalls, steady stretches and one long hold-off.
   initial begin
      int hold;
      int taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         hold = receiver_steady ? 0 : $urandom_range(0, 11);
         if (taken == 200)
            hold = HOLD_OFF;
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (!rsp_tvalid);
         @(posedge clock);
         taken++;
         if (taken % 64 == 0)
            receiver_steady = ($urandom_range(0, 3) == 0);
      end
   end

   // Request side: directed operations, then random traffic in phases.
   initial begin
      int regime;
      int roll;
      logic [1:0] op;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty list: tick, dispatch with nothing due, and the unused opcode.
      send_request(OP_TICK, 8'd0, 16'd0, 16'd0);
      send_request(OP_DISPATCH, 8'd0, 16'd0, 16'd0);
      send_request(OP_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF);
      // Extremes of every field.
      send_request(OP_ADD, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_request(OP_ADD, 8'h00, 16'd0, 16'd0);
      // A zero delay head is not due until a tick has seen it.
      send_request(OP_DISPATCH, 8'd0, 16'd0, 16'd0);
      send_request(OP_TICK, 8'd0, 16'd0, 16'd0);
      send_request(OP_TICK, 8'd0, 16'd0, 16'd0);
      send_request(OP_DISPATCH, 8'd0, 16'd0, 16'd0);
      // Equal delays: the later add goes first; the periodic one comes back.
      send_request(OP_ADD, 8'd10, 16'd2, 16'd3);
      send_request(OP_ADD, 8'd11, 16'd2, 16'd0);
      send_request(OP_TICK, 8'd0, 16'd0, 16'd0);
      send_request(OP_TICK, 8'd0, 16'd0, 16'd0);
      send_request(OP_DISPATCH, 8'd0, 16'd0, 16'd0);
      send_request(OP_TICK, 8'd0, 16'd0, 16'd0);
      send_request(OP_DISPATCH, 8'd0, 16'd0, 16'd0);
      // Fill the table and add once more into a full table.
      for (int i = 0; i < 15; i++)
         send_request(OP_ADD, 8'(20 + i), 16'($urandom_range(1, 4)), 16'd0);

      regime = 0;
      for (int n = 0; n < 900; n++) begin
         if (n % 60 == 0) begin
            regime        = $urandom_range(0, 2);
            sender_steady = ($urandom_range(0, 3) == 0);
         end
         roll = $urandom_range(0, 99);
         case (regime)
            // Add heavy, so the table runs full.
            1: op = (roll < 65) ? OP_ADD : (roll < 85) ? OP_TICK :
                    (roll < 97) ? OP_DISPATCH : OP_UNUSED;
            // Drain: mostly ticks and dispatches.
            2: op = (roll < 10) ? OP_ADD : (roll < 60) ? OP_TICK :
                    (roll < 97) ? OP_DISPATCH : OP_UNUSED;
            default: op = (roll < 30) ? OP_ADD : (roll < 70) ? OP_TICK :
                          (roll < 95) ? OP_DISPATCH : OP_UNUSED;
         endcase
         send_request(op, 8'($urandom_range(0, 255)), pick_delay(), pick_period());
      end
      req_tvalid <= 1'b0;

      while (results_pending != 0) @(negedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
